FILE: rtl/core/tty_line_discipline_defines.svh
// assertion helpers for the line discipline
`ifndef TTY_LINE_DISCIPLINE_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_DEFINES_SVH
`define TLD_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define TLD_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`endif

FILE: rtl/core/tld_pkg.sv
package tld_pkg;
   localparam int RING_DEPTH = 1024;
   localparam int PTR_W = $clog2(RING_DEPTH);

   localparam logic [1:0] OP_RX     = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [3:0] K_NONE  = 4'd0;
   localparam logic [3:0] K_ECHO  = 4'd1;
   localparam logic [3:0] K_CARET = 4'd2;
   localparam logic [3:0] K_ERASE = 4'd3;
   localparam logic [3:0] K_INTR  = 4'd4;
   localparam logic [3:0] K_QUIT  = 4'd5;
   localparam logic [3:0] K_DATA  = 4'd6;
   localparam logic [3:0] K_EOF   = 4'd7;
   localparam logic [3:0] K_EMPTY = 4'd8;

   localparam logic [2:0] R_MODE  = 3'd0;
   localparam logic [2:0] R_EOF   = 3'd1;
   localparam logic [2:0] R_EOL   = 3'd2;
   localparam logic [2:0] R_ERASE = 3'd3;
   localparam logic [2:0] R_INTR  = 3'd4;
   localparam logic [2:0] R_KILL  = 3'd5;
   localparam logic [2:0] R_QUIT  = 3'd6;
   localparam logic [2:0] R_SUSP  = 3'd7;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] char_in;
   } req_type;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] byte_a;
      logic [7:0] byte_b;
      logic [9:0] erase_count;
      logic       line_committed;
      logic       dropped;
   } rsp_type;

   typedef struct packed {
      logic [6:0] mode;
      logic [7:0] eof_c;
      logic [7:0] eol_c;
      logic [7:0] erase_c;
      logic [7:0] intr_c;
      logic [7:0] kill_c;
      logic [7:0] quit_c;
      logic [7:0] susp_c;
   } cfg_type;

   // datapath commands
   typedef struct packed {
      logic decode;     // classify the latched item, apply effects that need no ring walk or read
      logic back_rd;    // read the byte before write_pos
      logic back_step;  // step write_pos back one, using fetched byte
      logic rd_fetch;   // read the byte at read_pos
      logic rd_done;    // deliver fetched byte
   } cmd_type;

   // datapath status
   typedef struct packed {
      logic need_back;  // decoded an erase or kill with a nonempty line
      logic need_read;  // decoded a read with data available
      logic cont;       // another byte must be walked back
   } sts_type;
endpackage

FILE: rtl/core/tld_datapath.sv
module tld_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tld_pkg::req_type  req_data,
   input  tld_pkg::cfg_type  cfg,
   input  logic              csr_we,
   input  logic [2:0]        csr_idx,
   input  tld_pkg::cmd_type  cmd,
   output tld_pkg::sts_type  sts,
   output tld_pkg::rsp_type  result
);
   localparam int W = tld_pkg::PTR_W;

   logic [7:0] ring_mem [tld_pkg::RING_DEPTH];
   logic [7:0] rdata_ff;
   logic [W-1:0] rd_ff, ln_ff, wr_ff;
   logic [7:0] eofc_ff;
   logic [9:0] cnt_ff;
   logic       kill_ff;
   tld_pkg::rsp_type res_ff;

   logic [W-1:0] wr_prev, wr_next;
   logic [7:0]   c;
   logic canon, isig;
   assign c       = req_data.char_in;
   assign canon   = cfg.mode[0];
   assign isig    = cfg.mode[1];
   assign wr_prev = wr_ff - W'(1);
   assign wr_next = wr_ff + W'(1);

   logic is_eof, is_erase, is_intr, is_kill, is_quit, is_susp, special, doecho;
   always_comb begin
      is_eof   = canon && c == cfg.eof_c;
      is_erase = canon && c == cfg.erase_c;
      is_intr  = isig && c == cfg.intr_c;
      is_kill  = canon && c == cfg.kill_c;
      is_quit  = isig && c == cfg.quit_c;
      is_susp  = isig && c == cfg.susp_c;
      special  = (c < 8'h20 || c == 8'h7F) && c != 8'h09 && c != 8'h0A && c != 8'h0D;
      doecho   = cfg.mode[2] || (cfg.mode[5] && c == 8'h0A);
   end

   logic stepcont;
   assign stepcont = (rdata_ff[7:6] == 2'b10) && (ln_ff != wr_prev);

   always_comb begin
      sts.need_back = 1'b0;
      sts.need_read = 1'b0;
      if (req_data.operation == tld_pkg::OP_RX && !is_eof && (is_erase ||
          (!is_intr && is_kill)))
         sts.need_back = ln_ff != wr_ff;
      if (req_data.operation == tld_pkg::OP_READ && eofc_ff == 8'd0)
         sts.need_read = ln_ff != rd_ff;
      // keep walking: mid-character, or kill with more line left
      sts.cont = (ln_ff != wr_prev) && (stepcont || kill_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.back_rd)  rdata_ff <= ring_mem[wr_prev];
      if (cmd.rd_fetch) rdata_ff <= ring_mem[rd_ff];
      if (cmd.decode && req_data.operation == tld_pkg::OP_RX && !is_eof &&
          !is_erase && !is_intr && !is_kill && !is_quit && !is_susp &&
          wr_next != rd_ff)
         ring_mem[wr_ff] <= c;
   end

   always_ff @(posedge clock) begin
      tld_pkg::rsp_type r;
      logic [W-1:0] nw;
      r  = res_ff;
      nw = wr_ff;
      if (reset) begin
         rd_ff <= '0; ln_ff <= '0; wr_ff <= '0; eofc_ff <= '0;
         cnt_ff <= '0; kill_ff <= 1'b0;
      end else begin
         if (csr_we && csr_idx == tld_pkg::R_MODE && !cfg.mode[0]) ln_ff <= wr_ff;
         if (cmd.decode) begin
            r = '0;
            cnt_ff  <= '0;
            kill_ff <= is_kill && !is_erase;
            unique case (req_data.operation)
               tld_pkg::OP_RX: begin
                  if (is_eof) begin
                     if (ln_ff != wr_ff) begin
                        ln_ff <= wr_ff; r.line_committed = 1'b1;
                     end else if (eofc_ff != 8'hFF) eofc_ff <= eofc_ff + 8'd1;
                  end else if (is_erase || (!is_intr && is_kill)) begin
                     // handled by walk
                  end else if (is_intr) begin
                     if (!cfg.mode[6]) begin
                        ln_ff <= wr_ff; r.line_committed = ln_ff != wr_ff;
                     end
                     r.kind = tld_pkg::K_INTR;
                  end else if (is_quit) r.kind = tld_pkg::K_QUIT;
                  else if (is_susp) begin
                  end else begin
                     if (doecho) begin
                        if (special) begin
                           r.kind   = tld_pkg::K_CARET;
                           r.byte_a = 8'h5E;
                           r.byte_b = (c + 8'd64) & 8'h7F;
                        end else begin
                           r.kind   = tld_pkg::K_ECHO;
                           r.byte_a = c;
                        end
                     end
                     if (wr_next != rd_ff) nw = wr_next;
                     else r.dropped = 1'b1;
                     wr_ff <= nw;
                     if (!canon || c == 8'h0A || c == cfg.eol_c) begin
                        ln_ff <= nw; r.line_committed = ln_ff != nw;
                     end
                  end
               end
               tld_pkg::OP_READ: begin
                  if (eofc_ff != 8'd0) begin
                     eofc_ff <= eofc_ff - 8'd1; r.kind = tld_pkg::K_EOF;
                  end else if (ln_ff == rd_ff) r.kind = tld_pkg::K_EMPTY;
               end
               tld_pkg::OP_FLUSH: begin
                  rd_ff <= '0; ln_ff <= '0; wr_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.back_step) begin
            wr_ff <= wr_prev;
            // a character finishes on a byte that is not a continuation byte, or at the line start
            if (!stepcont || ln_ff == wr_prev) begin
               if (cnt_ff != 10'h3FF) cnt_ff <= cnt_ff + 10'd1;
               if ((kill_ff ? cfg.mode[4] : cfg.mode[3])) begin
                  r.kind = tld_pkg::K_ERASE;
                  r.erase_count = (cnt_ff != 10'h3FF) ? cnt_ff + 10'd1 : cnt_ff;
               end
            end
         end
         if (cmd.rd_done) begin
            r.kind   = tld_pkg::K_DATA;
            r.byte_a = rdata_ff;
            rd_ff <= rd_ff + W'(1);
         end
         res_ff <= r;
      end
   end

   assign result = res_ff;
endmodule

FILE: rtl/core/tld_control.sv
`include "tty_line_discipline_defines.svh"
module tld_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  tld_pkg::sts_type sts,
   output tld_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {S_IDLE, S_DEC, S_BRD, S_BSTEP, S_RFETCH, S_RDONE, S_OUT}
      state_type;
   state_type state_ff;

   always_comb begin
      cmd = '0;
      cmd.decode    = state_ff == S_DEC;
      cmd.back_rd   = state_ff == S_BRD;
      cmd.back_step = state_ff == S_BSTEP;
      cmd.rd_fetch  = state_ff == S_RFETCH;
      cmd.rd_done   = state_ff == S_RDONE;
   end
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else begin
         unique case (state_ff)
            S_IDLE:   if (req_valid) state_ff <= S_DEC;
            S_DEC:    state_ff <= sts.need_back ? S_BRD :
                                  sts.need_read ? S_RFETCH : S_OUT;
            S_BRD:    state_ff <= S_BSTEP;
            S_BSTEP:  state_ff <= sts.cont ? S_BRD : S_OUT;
            S_RFETCH: state_ff <= S_RDONE;
            S_RDONE:  state_ff <= S_OUT;
            S_OUT:    if (rsp_ready) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   `TLD_ASSERT_IMP(a_excl, clock, reset, req_ready, !rsp_valid)
   `TLD_ASSERT_NXT(a_take, clock, reset, req_valid && req_ready, state_ff == S_DEC)
   `TLD_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule

FILE: rtl/core/tty_line_discipline.sv
// channel | direction | payload
// req     | in        | operation, char_in
// rsp     | out       | kind, byte_a, byte_b, erase_count, line_committed, dropped
// csr     | in        | index 0..7, data
// an item passes the idle, decode and output states; a read of data adds a fetch and a deliver state,
// erase and kill add a read and a step state per byte walked back (one ring read port)
// reset is synchronous, clears positions and eof count and loads register defaults; ring is not cleared
// one item in flight; a stalled result holds the block until transferred
module tty_line_discipline (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tld_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tld_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_data
);
   tld_pkg::req_type req_ff;
   tld_pkg::cfg_type cfg_ff, cfg_in;
   tld_pkg::cmd_type cmd;
   tld_pkg::sts_type sts;
   logic csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index)
         tld_pkg::R_MODE:  cfg_in.mode    = csr_data[6:0];
         tld_pkg::R_EOF:   cfg_in.eof_c   = csr_data;
         tld_pkg::R_EOL:   cfg_in.eol_c   = csr_data;
         tld_pkg::R_ERASE: cfg_in.erase_c = csr_data;
         tld_pkg::R_INTR:  cfg_in.intr_c  = csr_data;
         tld_pkg::R_KILL:  cfg_in.kill_c  = csr_data;
         tld_pkg::R_QUIT:  cfg_in.quit_c  = csr_data;
         tld_pkg::R_SUSP:  cfg_in.susp_c  = csr_data;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: 7'd31, eof_c: 8'd4, eol_c: 8'd0, erase_c: 8'd8,
                     intr_c: 8'd3, kill_c: 8'd21, quit_c: 8'd28, susp_c: 8'd26};
      end else if (csr_we) cfg_ff <= cfg_in;
      // latch the item on its transfer
      if (req_valid && req_ready) req_ff <= req_data;
   end

   tld_control u_ctl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   // mode write sees the new flags through cfg_in
   tld_datapath u_dp (
      .clock, .reset, .req_data(req_ff), .cfg(csr_we ? cfg_in : cfg_ff), .csr_we,
      .csr_idx(csr_index), .cmd, .sts, .result(rsp_data)
   );
endmodule

FILE: sim/tb_tty_line_discipline.sv
module tb_tty_line_discipline;
   timeunit 1ns;
   timeprecision 1ps;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   tld_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   tld_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [2:0]       csr_index;
   logic [7:0]       csr_data;

   tty_line_discipline dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow copy of the line discipline state
   logic [7:0] ring_bytes [tld_pkg::RING_DEPTH];
   logic [tld_pkg::PTR_W-1:0] rd_ptr, line_ptr, wr_ptr;
   logic [7:0] eof_pending;
   // shadow copy of the registers, indexed by register code
   logic [7:0] regs [8];

   tld_pkg::rsp_type echo_q [$];   // expected results, oldest first
   int fails;
   int gap_pct, stall_pct;

   // remove one utf-8 character from the pending line
   function automatic bit back_char();
      bit more;
      if (line_ptr == wr_ptr) return 1'b0;
      do begin
         wr_ptr = wr_ptr - 1'b1;
         more = (ring_bytes[wr_ptr] & 8'hC0) == 8'h80;
      end while (more && line_ptr != wr_ptr);
      return 1'b1;
   endfunction

   function automatic logic commit_pending();
      logic moved;
      moved = (line_ptr != wr_ptr);
      line_ptr = wr_ptr;
      return moved;
   endfunction

   // expected result of one transfer on the input channel; updates the shadow state
   function automatic tld_pkg::rsp_type discipline(tld_pkg::req_type it);
      tld_pkg::rsp_type r;
      logic [7:0] c;
      logic [6:0] m;
      bit canon, isig;
      int n;
      r = '0;
      c = it.char_in;
      m = regs[tld_pkg::R_MODE][6:0];
      canon = m[0];
      isig = m[1];
      n = 0;
      case (it.operation)
         tld_pkg::OP_RX: begin
            if (canon && c == regs[tld_pkg::R_EOF]) begin
               if (line_ptr != wr_ptr) r.line_committed = commit_pending();
               else if (eof_pending != 8'hFF) eof_pending++;
            end else if (canon && c == regs[tld_pkg::R_ERASE]) begin
               if (back_char() && m[3]) begin
                  r.kind = tld_pkg::K_ERASE;
                  r.erase_count = 10'd1;
               end
            end else if (isig && c == regs[tld_pkg::R_INTR]) begin
               if (!m[6]) r.line_committed = commit_pending();
               r.kind = tld_pkg::K_INTR;
            end else if (canon && c == regs[tld_pkg::R_KILL]) begin
               while (back_char()) n++;
               if (m[4] && n > 0) begin
                  r.kind = tld_pkg::K_ERASE;
                  r.erase_count = (n > 1023) ? 10'd1023 : 10'(n);
               end
            end else if (isig && c == regs[tld_pkg::R_QUIT]) begin
               r.kind = tld_pkg::K_QUIT;
            end else if (isig && c == regs[tld_pkg::R_SUSP]) begin
               r.kind = tld_pkg::K_NONE;
            end else begin
               if (m[2] || (m[5] && c == 8'h0A)) begin
                  if ((c < 8'h20 || c == 8'h7F) && c != 8'h09 && c != 8'h0A && c != 8'h0D)
                  begin
                     r.kind = tld_pkg::K_CARET;
                     r.byte_a = 8'h5E;
                     r.byte_b = (c + 8'd64) & 8'h7F;
                  end else begin
                     r.kind = tld_pkg::K_ECHO;
                     r.byte_a = c;
                  end
               end
               if (tld_pkg::PTR_W'(wr_ptr + 1'b1) != rd_ptr) begin
                  ring_bytes[wr_ptr] = c;
                  wr_ptr = wr_ptr + 1'b1;
               end else begin
                  r.dropped = 1'b1;
               end
               if (!canon || c == 8'h0A || c == regs[tld_pkg::R_EOL])
                  r.line_committed = commit_pending();
            end
         end
         tld_pkg::OP_READ: begin
            if (eof_pending != 0) begin
               eof_pending--;
               r.kind = tld_pkg::K_EOF;
            end else if (line_ptr != rd_ptr) begin
               r.kind = tld_pkg::K_DATA;
               r.byte_a = ring_bytes[rd_ptr];
               rd_ptr = rd_ptr + 1'b1;
            end else begin
               r.kind = tld_pkg::K_EMPTY;
            end
         end
         tld_pkg::OP_FLUSH: begin
            rd_ptr = '0;
            line_ptr = '0;
            wr_ptr = '0;
         end
         default: ;
      endcase
      return r;
   endfunction

   // one transfer on the input channel, with random idle cycles ahead of it
   task automatic send(tld_pkg::req_type it, bit typed, tld_pkg::rsp_type want);
      tld_pkg::rsp_type p;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (!req_ready);
      p = discipline(it);
      echo_q.push_back(typed ? want : p);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (echo_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write; caller lowers csr_valid after the last one
   task automatic csr_write(logic [2:0] idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == tld_pkg::R_MODE) begin
         regs[tld_pkg::R_MODE] = {1'b0, val[6:0]};
         if (!val[0]) line_ptr = wr_ptr;
      end else begin
         regs[idx] = val;
      end
   endtask

   // full register set: given mode, special characters random with extremes
   task automatic setup(logic [7:0] mode);
      logic [7:0] v;
      csr_write(tld_pkg::R_MODE, mode);
      for (int i = 1; i < 8; i++) begin
         case ($urandom_range(3))
            0: v = 8'h00;
            1: v = 8'hFF;
            default: v = 8'($urandom_range(31));
         endcase
         csr_write(3'(i), v);
      end
      csr_valid <= 1'b0;
   endtask

   // random transfer, biased toward the configured special characters
   task automatic random_item();
      tld_pkg::req_type it;
      int sel;
      sel = $urandom_range(99);
      it.char_in = 8'($urandom_range(255));
      if (sel < 56) begin
         it.operation = tld_pkg::OP_RX;
         case ($urandom_range(3))
            0: it.char_in = 8'($urandom_range(8'h7E, 8'h20));
            1: it.char_in = regs[$urandom_range(7, 1)];
            2: it.char_in = 8'h0A;
            default: ;
         endcase
      end else if (sel < 94) it.operation = tld_pkg::OP_READ;
      else if (sel < 98) it.operation = tld_pkg::OP_FLUSH;
      else it.operation = tld_pkg::OP_UNUSED;
      send(it, 1'b0, '0);
   endtask

   // directed table
   typedef struct {
      logic [1:0]       op;
      logic [7:0]       ch;
      bit               typed;
      tld_pkg::rsp_type want;
   } step_row_type;

   localparam int NUM_ROWS = 25;
   step_row_type steps [NUM_ROWS];

   initial begin
      steps = '{
         '{tld_pkg::OP_READ,  8'h00, 1, '{tld_pkg::K_EMPTY, 8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'h04, 1, '{tld_pkg::K_NONE,  8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_READ,  8'h00, 1, '{tld_pkg::K_EOF,   8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'h61, 0, '0},
         '{tld_pkg::OP_RX,    8'hC3, 0, '0},   // two-byte utf-8 character
         '{tld_pkg::OP_RX,    8'hA9, 0, '0},
         '{tld_pkg::OP_RX,    8'h08, 0, '0},   // erase backs over both bytes
         '{tld_pkg::OP_RX,    8'h01, 1, '{tld_pkg::K_CARET, 8'h5E, 8'h41, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'h7F, 1, '{tld_pkg::K_CARET, 8'h5E, 8'h3F, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'hFF, 1, '{tld_pkg::K_ECHO,  8'hFF, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'h09, 0, '0},
         '{tld_pkg::OP_RX,    8'h15, 0, '0},   // kill the line
         '{tld_pkg::OP_RX,    8'h62, 0, '0},
         '{tld_pkg::OP_RX,    8'h0A, 0, '0},
         '{tld_pkg::OP_READ,  8'h00, 0, '0},
         '{tld_pkg::OP_READ,  8'h00, 0, '0},
         '{tld_pkg::OP_RX,    8'h00, 0, '0},   // eol character
         '{tld_pkg::OP_RX,    8'h03, 0, '0},   // interrupt
         '{tld_pkg::OP_RX,    8'h1C, 1, '{tld_pkg::K_QUIT,  8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'h1A, 1, '{tld_pkg::K_NONE,  8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_RX,    8'h63, 0, '0},
         '{tld_pkg::OP_RX,    8'h04, 0, '0},   // eof with pending line commits it
         '{tld_pkg::OP_FLUSH, 8'h00, 1, '{tld_pkg::K_NONE,  8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_UNUSED, 8'hA5, 1, '{tld_pkg::K_NONE, 8'h00, 8'h00, 10'd0, 1'b0, 1'b0}},
         '{tld_pkg::OP_READ,  8'h00, 0, '0}
      };
   end

   // receiver side: random back-pressure on the result channel
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // result checking
   always @(posedge clock) begin
      tld_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (echo_q.size() == 0) begin
            $error("result transfer with nothing expected: %h", rsp_data);
            fails++;
         end else begin
            e = echo_q.pop_front();
            if (rsp_data.kind !== e.kind) begin
               $error("kind: expected %0d, got %0d", e.kind, rsp_data.kind);
               fails++;
            end
            if (rsp_data.byte_a !== e.byte_a) begin
               $error("byte_a: expected %h, got %h", e.byte_a, rsp_data.byte_a);
               fails++;
            end
            if (rsp_data.byte_b !== e.byte_b) begin
               $error("byte_b: expected %h, got %h", e.byte_b, rsp_data.byte_b);
               fails++;
            end
            if (rsp_data.erase_count !== e.erase_count) begin
               $error("erase_count: expected %0d, got %0d", e.erase_count,
                      rsp_data.erase_count);
               fails++;
            end
            if (rsp_data.line_committed !== e.line_committed) begin
               $error("line_committed: expected %b, got %b", e.line_committed,
                      rsp_data.line_committed);
               fails++;
            end
            if (rsp_data.dropped !== e.dropped) begin
               $error("dropped: expected %b, got %b", e.dropped, rsp_data.dropped);
               fails++;
            end
         end
      end
   end

   // watchdog
   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      tld_pkg::req_type it;
      logic [7:0] modes [6];
      fails = 0;
      gap_pct = 15;
      stall_pct = 76;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rsp_ready = 1'b0;
      rd_ptr = '0;
      line_ptr = '0;
      wr_ptr = '0;
      eof_pending = '0;
      regs = '{8'd31, 8'd4, 8'd0, 8'd8, 8'd3, 8'd21, 8'd28, 8'd26};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset settings
      foreach (steps[i]) begin
         it.operation = steps[i].op;
         it.char_in = steps[i].ch;
         send(it, steps[i].typed, steps[i].want);
      end
      drain();

      // random phases: mode extremes first, then mixed settings
      modes = '{8'h00, 8'h7F, 8'($urandom_range(127)), 8'($urandom_range(127)),
                8'h1F, 8'($urandom_range(127))};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 2) begin
            gap_pct = 76;
            stall_pct = 15;
         end else if (ph == 4) begin
            gap_pct = 0;
            stall_pct = 0;
         end
         setup(modes[ph]);
         for (int k = 0; k < 40; k++) begin
            // hold the sender off until the block has gone quiet
            if (ph == 3 && k == 20) begin
               req_valid <= 1'b0;
               while (echo_q.size() != 0) @(posedge clock);
            end
            random_item();
         end
         drain();
      end

      // fill the ring until bytes drop, then kill the whole line
      csr_write(tld_pkg::R_MODE, 8'h11);
      csr_write(tld_pkg::R_EOF, 8'h04);
      csr_write(tld_pkg::R_EOL, 8'h00);
      csr_write(tld_pkg::R_ERASE, 8'h08);
      csr_write(tld_pkg::R_KILL, 8'h15);
      csr_valid <= 1'b0;
      it.operation = tld_pkg::OP_FLUSH;
      it.char_in = 8'h00;
      send(it, 1'b0, '0);
      it.operation = tld_pkg::OP_RX;
      it.char_in = 8'h78;
      repeat (tld_pkg::RING_DEPTH + 1) send(it, 1'b0, '0);
      it.char_in = 8'h15;
      send(it, 1'b0, '0);
      drain();
      repeat (20) @(posedge clock);

      if (fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/tld_pkg.sv
rtl/core/tld_datapath.sv
rtl/core/tld_control.sv
rtl/core/tty_line_discipline.sv
sim/tb_tty_line_discipline.sv
